### rtl/core/pnlcond_pkg.sv
// ----------------------------------------------------------------------------
// pnlcond_pkg
// shared types and constants for the panel pot and switch conditioner
// ----------------------------------------------------------------------------
`default_nettype none

package pnlcond_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    localparam int CH_W     = 4;
    localparam int RAW_W    = 10;
    localparam int TIME_W   = 32;
    localparam int VALUE_W  = 16;
    localparam int SEQ_W    = 8;
    localparam int CFG_IX_W = 3;
    localparam int CFG_D_W  = 16;
    localparam int WIN_W    = 3;
    localparam int LAST_W   = RAW_W + 1;

    // switch window upper bounds
    localparam logic [RAW_W-1:0] WIN0_MAX = 10'd126;
    localparam logic [RAW_W-1:0] WIN1_MAX = 10'd382;
    localparam logic [RAW_W-1:0] WIN2_MAX = 10'd640;

    localparam logic [WIN_W-1:0] NO_WINDOW = 3'd4;
    localparam int SCALE_DIV = 1023;

    localparam logic [15:0]      MASK_RST   = 16'd33824;
    localparam logic [CH_W-1:0]  SHIFT_RST  = 4'd11;
    localparam logic [RAW_W-1:0] WINDOW_RST = 10'd20;
    localparam logic [RAW_W-1:0] MOVE_RST   = 10'd82;
    localparam logic [15:0]      SETTLE_RST = 16'd50;

    localparam logic [LAST_W-1:0] LAST_INVALID = 11'h400;

    typedef enum logic [0:0] {
        REQ_SAMPLE = 1'b0,
        REQ_TOGGLE = 1'b1
    } req_kind_t;

    typedef enum logic [CFG_IX_W-1:0] {
        CFG_MASK       = 3'd0,
        CFG_SHIFT_CH   = 3'd1,
        CFG_CATCH_WIN  = 3'd2,
        CFG_CATCH_MOVE = 3'd3,
        CFG_SETTLE     = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic              req_type;
        logic [CH_W-1:0]   channel;
        logic [RAW_W-1:0]  raw_sample;
        logic [TIME_W-1:0] now_ms;
    } req_t;

    typedef struct packed {
        logic [CH_W-1:0]    out_channel;
        logic               use_secondary;
        logic [VALUE_W-1:0] out_value;
        logic [SEQ_W-1:0]   seq_num;
    } res_t;

    typedef struct packed {
        logic [WIN_W-1:0]  seen;
        logic [TIME_W-1:0] entry_time;
        logic [WIN_W-1:0]  sent;
    } win_entry_t;

    localparam win_entry_t WIN_ENTRY_RST = '{seen: NO_WINDOW, entry_time: '0, sent: NO_WINDOW};

endpackage

`default_nettype wire

### rtl/core/panel_pot_and_switch_conditioner.sv
// ----------------------------------------------------------------------------
// panel_pot_and_switch_conditioner
// pot scaling, shift soft takeover and four-position switch settling
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps up. An accepted
// request is registered into the second stage while the per-channel switch
// window store is read; the second stage then decides, writes the entry
// back and loads the result register. The last write is forwarded so that
// back-to-back requests on one channel see fresh data. A stalled result
// holds the second stage, which holds the request side. The configuration
// port is always ready; writes belong in idle periods, with no request in
// flight.
`default_nettype none

module panel_pot_and_switch_conditioner (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                req_valid,
    output logic                                     req_stall,
    input  wire pnlcond_pkg::req_t                   req,
    output logic                                     res_valid,
    input  wire logic                                res_stall,
    output pnlcond_pkg::res_t                        res,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [pnlcond_pkg::CFG_IX_W-1:0]    cfg_index,
    input  wire logic [pnlcond_pkg::CFG_D_W-1:0]     cfg_data
);

    localparam int NCH = pnlcond_pkg::NUM_CHANNELS;
    localparam int AW  = pnlcond_pkg::CH_AW;

    // configuration
    logic [15:0]                     ranged_mask_reg;
    logic [pnlcond_pkg::CH_W-1:0]    shift_ch_reg;
    logic [pnlcond_pkg::RAW_W-1:0]   catch_win_reg;
    logic [pnlcond_pkg::RAW_W-1:0]   catch_move_reg;
    logic [15:0]                     settle_reg;

    // scalar state
    logic                              shift_on_reg, shift_on_next;
    logic                              catch_active_reg, catch_active_next;
    logic [pnlcond_pkg::RAW_W-1:0]     catch_goal_reg, catch_goal_next;
    logic [pnlcond_pkg::RAW_W-1:0]     catch_prev_reg, catch_prev_next;
    logic [pnlcond_pkg::RAW_W-1:0]     catch_origin_reg, catch_origin_next;
    logic [pnlcond_pkg::LAST_W-1:0]    last_pri_reg, last_pri_next;
    logic [pnlcond_pkg::LAST_W-1:0]    last_sec_reg, last_sec_next;
    logic [pnlcond_pkg::SEQ_W-1:0]     frame_count_reg, frame_count_next;

    // window store
    pnlcond_pkg::win_entry_t win_mem [NCH];
    pnlcond_pkg::win_entry_t win_rd_reg;
    logic [NCH-1:0]          win_valid_reg;
    logic                    mem_we;
    pnlcond_pkg::win_entry_t mem_wdata;
    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    pnlcond_pkg::win_entry_t fwd_data_reg;

    // second stage
    logic                              s1_valid_reg, s1_valid_next;
    logic                              s1_toggle_reg;
    logic [pnlcond_pkg::CH_W-1:0]      s1_ch_reg;
    logic [AW-1:0]                     s1_addr_reg;
    logic                              s1_in_range_reg;
    logic [pnlcond_pkg::RAW_W-1:0]     s1_raw_reg;
    logic [pnlcond_pkg::TIME_W-1:0]    s1_now_reg;

    // result register
    logic                res_valid_reg, res_valid_next;
    pnlcond_pkg::res_t   res_data_reg, res_data_next;

    logic                              accept;
    logic                              s1_fire;
    logic [pnlcond_pkg::CH_W-1:0]      in_ch;
    logic                              in_toggle;
    logic [AW-1:0]                     in_addr;

    logic                              shift_new;
    logic [pnlcond_pkg::LAST_W-1:0]    target;
    logic                              arm;
    logic                              act_e;
    logic [pnlcond_pkg::RAW_W-1:0]     goal_e;
    logic [pnlcond_pkg::RAW_W-1:0]     prev_e;
    logic [pnlcond_pkg::RAW_W-1:0]     origin_e;
    logic                              is_shift;
    logic                              sec;
    logic                              ranged;
    logic                              crossed;
    logic                              moved;
    logic                              hold;
    logic [1:0]                        win_now;
    logic [pnlcond_pkg::TIME_W-1:0]    elapsed;
    pnlcond_pkg::win_entry_t           entry_cur;
    logic                              emit;
    logic [pnlcond_pkg::VALUE_W-1:0]   emit_value;

    function automatic logic [pnlcond_pkg::RAW_W-1:0] abs_diff(
        input logic [pnlcond_pkg::RAW_W-1:0] a,
        input logic [pnlcond_pkg::RAW_W-1:0] b
    );
        return (a >= b) ? (a - b) : (b - a);
    endfunction

    function automatic logic [1:0] window_of(input logic [pnlcond_pkg::RAW_W-1:0] r);
        logic [1:0] w;
        if (r <= pnlcond_pkg::WIN0_MAX)
        begin
            w = 2'd0;
        end
        else if (r <= pnlcond_pkg::WIN1_MAX)
        begin
            w = 2'd1;
        end
        else if (r <= pnlcond_pkg::WIN2_MAX)
        begin
            w = 2'd2;
        end
        else
        begin
            w = 2'd3;
        end
        return w;
    endfunction

    // r * 65535 / 1023 = 64 * r + floor(63 * r / 1023), the second part by
    // a shift and one compare-and-increment correction
    function automatic logic [pnlcond_pkg::VALUE_W-1:0] scale_raw(
        input logic [pnlcond_pkg::RAW_W-1:0] r
    );
        logic [15:0] y;
        logic [5:0]  q0;
        logic [10:0] rem;
        logic [5:0]  q;
        y   = {r, 6'b0} - {6'b0, r};
        q0  = y[15:10];
        rem = {1'b0, y[9:0]} + {5'b0, q0};
        q   = q0 + {5'b0, (rem >= 11'(pnlcond_pkg::SCALE_DIV))};
        return {r, 6'b0} + {10'b0, q};
    endfunction

    assign cfg_ready = 1'b1;
    assign res_valid = res_valid_reg;
    assign res       = res_data_reg;

    assign s1_fire   = s1_valid_reg && (!res_valid_reg || !res_stall);
    assign req_stall = s1_valid_reg && !s1_fire;
    assign accept    = req_valid && !req_stall;

    assign in_toggle = (req.req_type == pnlcond_pkg::REQ_TOGGLE);
    assign in_ch     = in_toggle ? shift_ch_reg : req.channel;
    assign in_addr   = AW'(in_ch);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ranged_mask_reg <= pnlcond_pkg::MASK_RST;
            shift_ch_reg    <= pnlcond_pkg::SHIFT_RST;
            catch_win_reg   <= pnlcond_pkg::WINDOW_RST;
            catch_move_reg  <= pnlcond_pkg::MOVE_RST;
            settle_reg      <= pnlcond_pkg::SETTLE_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pnlcond_pkg::CFG_MASK:       ranged_mask_reg <= cfg_data;
                pnlcond_pkg::CFG_SHIFT_CH:   shift_ch_reg    <= cfg_data[pnlcond_pkg::CH_W-1:0];
                pnlcond_pkg::CFG_CATCH_WIN:  catch_win_reg   <= cfg_data[pnlcond_pkg::RAW_W-1:0];
                pnlcond_pkg::CFG_CATCH_MOVE: catch_move_reg  <= cfg_data[pnlcond_pkg::RAW_W-1:0];
                pnlcond_pkg::CFG_SETTLE:     settle_reg      <= cfg_data;
                default:                     ;
            endcase
        end
    end

    // window store: read at acceptance, written back from the second stage
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            win_mem[s1_addr_reg] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            win_rd_reg <= win_mem[in_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= mem_wdata;
        end
        if (accept)
        begin
            s1_toggle_reg   <= in_toggle;
            s1_ch_reg       <= in_ch;
            s1_addr_reg     <= in_addr;
            s1_in_range_reg <= (32'(in_ch) < 32'(NCH));
            s1_raw_reg      <= req.raw_sample;
            s1_now_reg      <= req.now_ms;
        end
        res_data_reg <= res_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_valid_reg    <= '0;
            fwd_valid_reg    <= 1'b0;
            s1_valid_reg     <= 1'b0;
            res_valid_reg    <= 1'b0;
            shift_on_reg     <= 1'b0;
            catch_active_reg <= 1'b0;
            catch_goal_reg   <= '0;
            catch_prev_reg   <= '0;
            catch_origin_reg <= '0;
            last_pri_reg     <= pnlcond_pkg::LAST_INVALID;
            last_sec_reg     <= pnlcond_pkg::LAST_INVALID;
            frame_count_reg  <= '0;
        end
        else
        begin
            if (mem_we)
            begin
                win_valid_reg[s1_addr_reg] <= 1'b1;
                fwd_valid_reg              <= 1'b1;
            end
            s1_valid_reg     <= s1_valid_next;
            res_valid_reg    <= res_valid_next;
            shift_on_reg     <= shift_on_next;
            catch_active_reg <= catch_active_next;
            catch_goal_reg   <= catch_goal_next;
            catch_prev_reg   <= catch_prev_next;
            catch_origin_reg <= catch_origin_next;
            last_pri_reg     <= last_pri_next;
            last_sec_reg     <= last_sec_next;
            frame_count_reg  <= frame_count_next;
        end
    end

    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == s1_addr_reg))
        begin
            entry_cur = fwd_data_reg;
        end
        else if (win_valid_reg[s1_addr_reg])
        begin
            entry_cur = win_rd_reg;
        end
        else
        begin
            entry_cur = pnlcond_pkg::WIN_ENTRY_RST;
        end

        shift_new = s1_toggle_reg ? !shift_on_reg : shift_on_reg;
        target    = shift_new ? last_sec_reg : last_pri_reg;
        arm       = s1_toggle_reg && s1_in_range_reg && !target[pnlcond_pkg::RAW_W] &&
                    (abs_diff(s1_raw_reg, target[pnlcond_pkg::RAW_W-1:0]) > catch_win_reg);
        act_e     = arm || catch_active_reg;
        goal_e    = arm ? target[pnlcond_pkg::RAW_W-1:0] : catch_goal_reg;
        prev_e    = arm ? s1_raw_reg : catch_prev_reg;
        origin_e  = arm ? s1_raw_reg : catch_origin_reg;

        is_shift  = (s1_ch_reg == shift_ch_reg);
        sec       = is_shift && shift_new;
        ranged    = ranged_mask_reg[s1_ch_reg];
        crossed   = ((prev_e <= goal_e) && (s1_raw_reg >= goal_e)) ||
                    ((prev_e >= goal_e) && (s1_raw_reg <= goal_e));
        moved     = (abs_diff(s1_raw_reg, origin_e) >= catch_move_reg);
        win_now   = window_of(s1_raw_reg);
        elapsed   = s1_now_reg - entry_cur.entry_time;

        shift_on_next     = shift_on_reg;
        catch_active_next = catch_active_reg;
        catch_goal_next   = catch_goal_reg;
        catch_prev_next   = catch_prev_reg;
        catch_origin_next = catch_origin_reg;
        last_pri_next     = last_pri_reg;
        last_sec_next     = last_sec_reg;
        frame_count_next  = frame_count_reg;
        mem_we            = 1'b0;
        mem_wdata         = entry_cur;
        emit              = 1'b0;
        emit_value        = '0;
        hold              = 1'b0;

        if (s1_fire)
        begin
            shift_on_next = shift_new;
            if (arm)
            begin
                catch_active_next = 1'b1;
                catch_goal_next   = goal_e;
                catch_prev_next   = prev_e;
                catch_origin_next = origin_e;
            end
            if (s1_in_range_reg)
            begin
                if (ranged)
                begin
                    if ({1'b0, win_now} != entry_cur.seen)
                    begin
                        // new window: restart the settle timer
                        mem_we               = 1'b1;
                        mem_wdata.seen       = {1'b0, win_now};
                        mem_wdata.entry_time = s1_now_reg;
                    end
                    else if ((elapsed >= {16'b0, settle_reg}) &&
                             ({1'b0, win_now} != entry_cur.sent))
                    begin
                        mem_we         = 1'b1;
                        mem_wdata.sent = {1'b0, win_now};
                        emit           = 1'b1;
                        emit_value     = {14'b0, win_now};
                    end
                end
                else
                begin
                    if (is_shift)
                    begin
                        if (act_e)
                        begin
                            if (crossed || moved)
                            begin
                                catch_active_next = 1'b0;
                            end
                            else
                            begin
                                hold = 1'b1;
                            end
                        end
                        catch_prev_next = s1_raw_reg;
                        if (!hold)
                        begin
                            if (sec)
                            begin
                                last_sec_next = {1'b0, s1_raw_reg};
                            end
                            else
                            begin
                                last_pri_next = {1'b0, s1_raw_reg};
                            end
                        end
                    end
                    emit       = !hold;
                    emit_value = scale_raw(s1_raw_reg);
                end
            end
        end

        s1_valid_next = accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_reg);

        res_data_next = res_data_reg;
        if (s1_fire)
        begin
            res_valid_next = emit;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
        if (emit)
        begin
            res_data_next.out_channel   = s1_ch_reg;
            res_data_next.use_secondary = sec;
            res_data_next.out_value     = emit_value;
            res_data_next.seq_num       = frame_count_reg;
            frame_count_next            = frame_count_reg + 8'd1;
        end
    end

    // a store write only comes from a request leaving the second stage
    assert property (@(posedge clk) disable iff (!rst_n) mem_we |-> s1_fire)
        else $error("window store written without a request in the second stage");

    // the request side only stalls behind an occupied second stage
    assert property (@(posedge clk) disable iff (!rst_n) req_stall |-> s1_valid_reg)
        else $error("request stalled with an empty second stage");

    // each result advances the frame count by exactly one
    assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (frame_count_reg == $past(frame_count_reg) + 8'd1))
        else $error("frame count did not advance with a result");

    // a new result shows only after the second stage fired
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid_reg) |-> $past(s1_fire))
        else $error("result appeared without a request behind it");

    // a held result keeps its sequence number
    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && res_stall) |=> (res_data_reg.seq_num == $past(res_data_reg.seq_num)))
        else $error("stalled result changed its sequence number");

endmodule

`default_nettype wire

### tb/sv/panel_pot_and_switch_conditioner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// panel_pot_and_switch_conditioner_tb
// self-checking bench for pot scaling, soft takeover and switch settling
// ----------------------------------------------------------------------------
// Requests are queued by the stimulus process and sent by a clocked driver
// that predicts the frame each accepted request should produce. A clocked
// monitor pulls frames with random back-pressure and checks them in order.
// The registers are rewritten between phases, when the block has drained.

module panel_pot_and_switch_conditioner_tb;

    import pnlcond_pkg::*;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_stall;
    req_t                req = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    res_t                res;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CFG_IX_W-1:0] cfg_index = '0;
    logic [CFG_D_W-1:0]  cfg_data = '0;

    req_t requests_queued[$];
    res_t frames_due[$];
    int   errors = 0;
    bit   calm = 1'b0;
    int   gap_left = 0;
    int   stall_left = 0;

    // predicted register copy
    logic [15:0]      m_mask = MASK_RST;
    logic [CH_W-1:0]  m_shift_ch = SHIFT_RST;
    logic [RAW_W-1:0] m_window = WINDOW_RST;
    logic [RAW_W-1:0] m_move = MOVE_RST;
    logic [15:0]      m_settle = SETTLE_RST;

    // predicted block state
    logic               shift_on = 1'b0;
    logic               catch_on = 1'b0;
    logic [RAW_W-1:0]   catch_goal = '0;
    logic [RAW_W-1:0]   catch_prev = '0;
    logic [RAW_W-1:0]   catch_origin = '0;
    logic [LAST_W-1:0]  last_pri = LAST_INVALID;
    logic [LAST_W-1:0]  last_sec = LAST_INVALID;
    logic [WIN_W-1:0]   win_seen [NUM_CHANNELS];
    logic [TIME_W-1:0]  win_stamp [NUM_CHANNELS];
    logic [WIN_W-1:0]   win_sent [NUM_CHANNELS];
    logic [SEQ_W-1:0]   frame_cnt = '0;

    // stimulus state
    logic [31:0] clock_ms;
    int          pot_pos = 512;

    panel_pot_and_switch_conditioner u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(64'd10_000_000);
        $display("TEST FAILED");
        $finish;
    end

    function automatic logic [RAW_W-1:0] distance(logic [RAW_W-1:0] a, logic [RAW_W-1:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    function automatic void send_frame(logic [CH_W-1:0] ch, logic sec, logic [VALUE_W-1:0] val);
        frames_due.push_back('{out_channel: ch, use_secondary: sec, out_value: val,
                               seq_num: frame_cnt});
        frame_cnt = frame_cnt + 1'b1;
    endfunction

    function automatic void condition_sample(logic [CH_W-1:0] ch, logic [RAW_W-1:0] raw,
                                             logic [TIME_W-1:0] stamp);
        logic             is_shift;
        logic             sec;
        logic [WIN_W-1:0] w;
        logic             crossed;
        logic             moved;
        is_shift = (ch == m_shift_ch);
        sec = is_shift && shift_on;
        if (m_mask[ch])
        begin
            w = (raw <= WIN0_MAX) ? 3'd0 : (raw <= WIN1_MAX) ? 3'd1 :
                (raw <= WIN2_MAX) ? 3'd2 : 3'd3;
            if (w != win_seen[ch])
            begin
                win_seen[ch] = w;
                win_stamp[ch] = stamp;
                return;
            end
            if ((stamp - win_stamp[ch]) < {16'd0, m_settle})
                return;
            if (w == win_sent[ch])
                return;
            win_sent[ch] = w;
            send_frame(ch, sec, {13'd0, w});
            return;
        end
        if (is_shift)
        begin
            if (catch_on)
            begin
                crossed = (catch_prev <= catch_goal && raw >= catch_goal) ||
                          (catch_prev >= catch_goal && raw <= catch_goal);
                moved = distance(raw, catch_origin) >= m_move;
                catch_prev = raw;
                if (!crossed && !moved)
                    return;
                catch_on = 1'b0;
            end
            catch_prev = raw;
            if (sec)
                last_sec = {1'b0, raw};
            else
                last_pri = {1'b0, raw};
        end
        send_frame(ch, sec, VALUE_W'((32'(raw) * 32'd65535) / 32'(SCALE_DIV)));
    endfunction

    function automatic void condition_request(req_t r);
        logic [LAST_W-1:0] target;
        if (r.req_type == REQ_SAMPLE)
        begin
            condition_sample(r.channel, r.raw_sample, r.now_ms);
            return;
        end
        shift_on = !shift_on;
        target = shift_on ? last_sec : last_pri;
        if (!target[RAW_W] && distance(r.raw_sample, target[RAW_W-1:0]) > m_window)
        begin
            catch_on = 1'b1;
            catch_goal = target[RAW_W-1:0];
            catch_prev = r.raw_sample;
            catch_origin = r.raw_sample;
        end
        condition_sample(m_shift_ch, r.raw_sample, r.now_ms);
    endfunction

    // mostly short idle spells, now and then a long one
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(1, 2);
        else if (pick < 93)
            return $urandom_range(3, 8);
        return $urandom_range(20, 60);
    endfunction

    // request driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                condition_request(req);
            if (req_valid && req_stall)
                req_valid <= 1'b1;
            else if (gap_left > 0)
            begin
                gap_left = gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (requests_queued.size() > 0)
            begin
                req <= requests_queued.pop_front();
                req_valid <= 1'b1;
                gap_left = (calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
            end
            else
                req_valid <= 1'b0;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: unexpected frame expected none actual ch=%0d sec=%0d val=%0d seq=%0d",
                             $time, res.out_channel, res.use_secondary, res.out_value,
                             res.seq_num);
                    errors++;
                end
                else if (res.out_channel !== frames_due[0].out_channel ||
                         res.use_secondary !== frames_due[0].use_secondary ||
                         res.out_value !== frames_due[0].out_value ||
                         res.seq_num !== frames_due[0].seq_num)
                begin
                    $display("%0t: frame mismatch expected ch=%0d sec=%0d val=%0d seq=%0d",
                             $time, frames_due[0].out_channel, frames_due[0].use_secondary,
                             frames_due[0].out_value, frames_due[0].seq_num);
                    $display("%0t:                actual ch=%0d sec=%0d val=%0d seq=%0d",
                             $time, res.out_channel, res.use_secondary, res.out_value,
                             res.seq_num);
                    errors++;
                    void'(frames_due.pop_front());
                end
                else
                    void'(frames_due.pop_front());
            end
            if (stall_left > 0)
            begin
                stall_left = stall_left - 1;
                res_stall <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                stall_left = idle_len() - 1;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    task automatic push_req(req_kind_t kind, int ch, int raw, logic [31:0] stamp);
        req_t r;
        r.req_type = kind;
        r.channel = ch[CH_W-1:0];
        r.raw_sample = raw[RAW_W-1:0];
        r.now_ms = stamp;
        requests_queued.push_back(r);
    endtask

    task automatic write_reg(cfg_idx_t ix, int val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= ix;
        cfg_data <= val[CFG_D_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (ix)
            CFG_MASK:       m_mask = val[15:0];
            CFG_SHIFT_CH:   m_shift_ch = val[CH_W-1:0];
            CFG_CATCH_WIN:  m_window = val[RAW_W-1:0];
            CFG_CATCH_MOVE: m_move = val[RAW_W-1:0];
            CFG_SETTLE:     m_settle = val[15:0];
            default:        ;
        endcase
    endtask

    // waits until every request has gone and every frame has come back, then
    // lets requests that make no frame clear the pipeline
    task automatic wait_idle();
        do
            @(negedge clk);
        while (requests_queued.size() != 0 || req_valid || frames_due.size() != 0);
        repeat (8) @(posedge clk);
    endtask

    task automatic advance_clock();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            clock_ms = clock_ms + $urandom_range(0, 20);
        else if (pick < 85)
            clock_ms = clock_ms + $urandom_range(20, 120);
        else if (pick < 96)
            clock_ms = clock_ms + $urandom_range(0, 80000);
        else
            clock_ms = $urandom();
    endtask

    task automatic fill_random(int n);
        int made;
        int pick;
        int ch;
        int w;
        int reps;
        int lo;
        int hi;
        made = 0;
        while (made < n)
        begin
            pick = $urandom_range(0, 99);
            advance_clock();
            if (pick < 30)
            begin
                // hold one window on a switch for a few samples so it can settle
                ch = $urandom_range(0, NUM_CHANNELS - 1);
                if (m_mask != 16'd0)
                    while (!m_mask[ch])
                        ch = $urandom_range(0, NUM_CHANNELS - 1);
                w = $urandom_range(0, 3);
                lo = (w == 0) ? 0 : (w == 1) ? int'(WIN0_MAX) + 1 :
                     (w == 2) ? int'(WIN1_MAX) + 1 : int'(WIN2_MAX) + 1;
                hi = (w == 0) ? int'(WIN0_MAX) : (w == 1) ? int'(WIN1_MAX) :
                     (w == 2) ? int'(WIN2_MAX) : 1023;
                reps = $urandom_range(2, 4);
                repeat (reps)
                begin
                    push_req(REQ_SAMPLE, ch, $urandom_range(lo, hi), clock_ms);
                    advance_clock();
                    made++;
                end
            end
            else if (pick < 45)
            begin
                if ($urandom_range(0, 4) == 0)
                    pot_pos = $urandom_range(0, 1023);
                push_req(REQ_TOGGLE, $urandom_range(0, 15), pot_pos, clock_ms);
                made++;
            end
            else if (pick < 78)
            begin
                // the shift pot wanders, sometimes jumping
                if ($urandom_range(0, 5) == 0)
                    pot_pos = $urandom_range(0, 1023);
                else
                    pot_pos = pot_pos + int'($urandom_range(0, 60)) - 30;
                if (pot_pos < 0)
                    pot_pos = 0;
                if (pot_pos > 1023)
                    pot_pos = 1023;
                push_req(REQ_SAMPLE, m_shift_ch, pot_pos, clock_ms);
                made++;
            end
            else
            begin
                push_req(REQ_SAMPLE, $urandom_range(0, 15), $urandom_range(0, 1023), clock_ms);
                made++;
            end
        end
    endtask

    task automatic set_all(int mask, int shift_ch, int window, int move, int settle);
        write_reg(CFG_MASK, mask);
        write_reg(CFG_SHIFT_CH, shift_ch);
        write_reg(CFG_CATCH_WIN, window);
        write_reg(CFG_CATCH_MOVE, move);
        write_reg(CFG_SETTLE, settle);
    endtask

    initial
    begin
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            win_seen[i] = NO_WINDOW;
            win_stamp[i] = '0;
            win_sent[i] = NO_WINDOW;
        end
        clock_ms = $urandom();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part on the reset settings
        push_req(REQ_SAMPLE, 0, 0, 32'd1000);
        push_req(REQ_SAMPLE, 1, 1023, 32'd1000);
        push_req(REQ_SAMPLE, 2, 512, 32'd1000);
        // switch: entry, just short of settling, settled, repeated window
        push_req(REQ_SAMPLE, 5, 0, 32'd1000);
        push_req(REQ_SAMPLE, 5, 126, 32'd1049);
        push_req(REQ_SAMPLE, 5, 126, 32'd1050);
        push_req(REQ_SAMPLE, 5, 100, 32'd1200);
        push_req(REQ_SAMPLE, 5, 127, 32'd1210);
        push_req(REQ_SAMPLE, 5, 382, 32'd1300);
        push_req(REQ_SAMPLE, 5, 383, 32'd1310);
        push_req(REQ_SAMPLE, 5, 640, 32'd1400);
        push_req(REQ_SAMPLE, 5, 641, 32'd1410);
        push_req(REQ_SAMPLE, 15, 1023, 32'd1410);
        // settling across the timestamp wrap
        push_req(REQ_SAMPLE, 10, 700, 32'hFFFF_FFF0);
        push_req(REQ_SAMPLE, 10, 1023, 32'h0000_0030);
        // shift: first toggle with nothing sent on the secondary side
        push_req(REQ_SAMPLE, 11, 100, 32'd2000);
        push_req(REQ_TOGGLE, 7, 900, 32'd2001);
        // takeover released by travel from the origin
        push_req(REQ_TOGGLE, 0, 900, 32'd2002);
        push_req(REQ_SAMPLE, 11, 850, 32'd2003);
        push_req(REQ_SAMPLE, 11, 700, 32'd2004);
        // takeover released by crossing the goal
        push_req(REQ_TOGGLE, 15, 850, 32'd2005);
        push_req(REQ_SAMPLE, 11, 910, 32'd2006);
        push_req(REQ_TOGGLE, 15, 1023, 32'd2007);
        push_req(REQ_SAMPLE, 11, 1023, 32'd2008);
        push_req(REQ_SAMPLE, 4, 1022, 32'd2009);
        wait_idle();

        for (int phase = 0; phase < 8; phase++)
        begin
            calm = (phase % 3 == 2);
            case (phase)
                0: set_all(16'hFFFF, 0, 0, 0, 0);
                1: set_all(16'h0000, 15, 1023, 1023, 65535);
                2: set_all(16'h8420, 11, 20, 82, 50);
                default:
                    set_all($urandom_range(0, 65535), $urandom_range(0, 15),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 60),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023)
                                                        : $urandom_range(0, 150),
                            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                        : $urandom_range(0, 80));
            endcase
            fill_random(200);
            wait_idle();
        end

        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
